// File: rtl/alle_pkg.sv
// Shared constants, types and command codes of the linked list engine.
package alle_pkg;

  localparam int unsigned SLOT_W   = 10;
  localparam int unsigned CAPACITY = 1 << SLOT_W;
  localparam int unsigned LINK_W   = SLOT_W + 1;
  localparam int unsigned COUNT_W  = SLOT_W + 1;
  localparam int unsigned DATA_W   = 32;

  typedef logic [SLOT_W-1:0]  slot_t;
  typedef logic [LINK_W-1:0]  link_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [DATA_W-1:0]  data_t;
  typedef logic [1:0]         cmd_t;

  // Forward link value that marks the end of a chain.
  localparam link_t LINK_NULL = LINK_W'(CAPACITY);

  localparam cmd_t CMD_APPEND = 2'd0;
  localparam cmd_t CMD_BEFORE = 2'd1;
  localparam cmd_t CMD_AFTER  = 2'd2;
  localparam cmd_t CMD_READ   = 2'd3;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

endpackage

// File: rtl/array_linked_list_engine_core.sv
// Top level of the array-based doubly linked list engine with free list.
//
// Usage: present a command word on command_i, position_i and payload_i and
// raise start_i; the word is taken at the rising edge where start_i is high
// and busy_o is low. Every command gives exactly one result word, shown for
// one cycle with done_o high; the receiver cannot stall, so it must take it.
// head_slot_o, tail_slot_o and count_o are valid alongside done_o.
//
// Steps per command, from the accepting edge until the block can take the
// next word:
//   read slot       one memory read, then the result register
//   refused insert  full check on the registered counters
//   insert/append   read free head and neighbour link, then two write
//                   passes over the single-port link memory
// The next-link memory's single port paces an insert: the free-head read,
// the neighbour read and two link writes all go through it.
// done_o rises in the cycle after a command's last busy cycle, or after the
// accepting edge of a refused insert, with the block ready for a new word.
//
// Reset: the next-link memory is swept after reset, one slot a cycle, to
// chain every slot to its successor; busy_o stays high until the sweep ends.
module array_linked_list_engine_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  alle_pkg::cmd_t   command_i,
  input  alle_pkg::slot_t  position_i,
  input  alle_pkg::data_t  payload_i,
  output logic             done_o,
  output logic             status_o,
  output alle_pkg::slot_t  slot_o,
  output alle_pkg::data_t  payload_out_o,
  output alle_pkg::slot_t  next_slot_o,
  output logic             next_valid_o,
  output alle_pkg::slot_t  prev_slot_o,
  output logic             prev_valid_o,
  output alle_pkg::slot_t  head_slot_o,
  output alle_pkg::slot_t  tail_slot_o,
  output alle_pkg::count_t count_o
);

  import alle_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_LINK  = 3'd3;
  localparam logic [2:0] ST_WR1   = 3'd4;
  localparam logic [2:0] ST_WR2   = 3'd5;

  // Control state
  logic [2:0] state_q, state_d;
  slot_t      clr_q, clr_d;
  link_t      free_head_q, free_head_d;
  slot_t      head_q, head_d;
  slot_t      tail_q, tail_d;
  count_t     entries_q, entries_d;
  logic       done_q, done_d;

  // Command word and working values
  cmd_t  cmd_q, cmd_d;
  slot_t pos_q, pos_d;
  data_t data_q, data_d;
  slot_t new_q, new_d;
  slot_t qprev_q, qprev_d;

  // Result word
  logic  res_status_q, res_status_d;
  slot_t res_slot_q, res_slot_d;
  data_t res_data_q, res_data_d;
  slot_t res_next_q, res_next_d;
  logic  res_nv_q, res_nv_d;
  slot_t res_prev_q, res_prev_d;
  logic  res_pv_q, res_pv_d;

  // Memory ports
  slot_t nx_addr, pv_addr, dt_addr;
  logic  nx_we, pv_we, dt_we;
  link_t nx_wdata, nx_rdata;
  slot_t pv_wdata, pv_rdata;
  data_t dt_wdata, dt_rdata;

  logic  is_app;
  logic  is_empty;

  alle_ram #(.WIDTH(LINK_W), .DEPTH(CAPACITY)) u_next_ram (
    .clk_i   (clk_i),
    .addr_i  (nx_addr),
    .we_i    (nx_we),
    .wdata_i (nx_wdata),
    .rdata_o (nx_rdata)
  );

  alle_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_prev_ram (
    .clk_i   (clk_i),
    .addr_i  (pv_addr),
    .we_i    (pv_we),
    .wdata_i (pv_wdata),
    .rdata_o (pv_rdata)
  );

  alle_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_data_ram (
    .clk_i   (clk_i),
    .addr_i  (dt_addr),
    .we_i    (dt_we),
    .wdata_i (dt_wdata),
    .rdata_o (dt_rdata)
  );

  // Counters hold their pre-command values until the last write pass, so
  // every decision below sees the list as it stood when the word came in.
  assign is_empty = (entries_q == '0);
  assign is_app   = is_empty || (cmd_q == CMD_APPEND);

  // All reads of an insert land before any write to the same memory, and a
  // new word is only taken once the writes are done: no forwarding needed.
  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    free_head_d  = free_head_q;
    head_d       = head_q;
    tail_d       = tail_q;
    entries_d    = entries_q;
    done_d       = 1'b0;
    cmd_d        = cmd_q;
    pos_d        = pos_q;
    data_d       = data_q;
    new_d        = new_q;
    qprev_d      = qprev_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_data_d   = res_data_q;
    res_next_d   = res_next_q;
    res_nv_d     = res_nv_q;
    res_prev_d   = res_prev_q;
    res_pv_d     = res_pv_q;

    nx_addr  = clr_q;
    nx_we    = 1'b0;
    nx_wdata = '0;
    pv_addr  = pos_q;
    pv_we    = 1'b0;
    pv_wdata = '0;
    dt_addr  = pos_q;
    dt_we    = 1'b0;
    dt_wdata = data_q;

    unique case (state_q)
      ST_CLEAR: begin
        // Chain each slot to its successor; the last one gets the null mark.
        nx_addr  = clr_q;
        nx_we    = 1'b1;
        nx_wdata = {1'b0, clr_q} + LINK_W'(1);
        clr_d    = clr_q + SLOT_W'(1);
        if (clr_q == SLOT_W'(CAPACITY - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        nx_addr = (command_i == CMD_READ) ? position_i : free_head_q[SLOT_W-1:0];
        pv_addr = position_i;
        dt_addr = position_i;
        if (start_i) begin
          cmd_d  = command_i;
          pos_d  = position_i;
          data_d = payload_i;
          new_d  = free_head_q[SLOT_W-1:0];
          if (command_i == CMD_READ) begin
            state_d = ST_READ;
          end else if ((entries_q >= COUNT_W'(CAPACITY)) || (free_head_q >= LINK_NULL)) begin
            // Refuse: the list stays as it is, result goes out next cycle.
            done_d       = 1'b1;
            res_status_d = STATUS_FULL;
            res_slot_d   = '0;
            res_data_d   = '0;
            res_next_d   = '0;
            res_nv_d     = 1'b0;
            res_prev_d   = '0;
            res_pv_d     = 1'b0;
          end else begin
            state_d = ST_LINK;
          end
        end
      end

      ST_READ: begin
        done_d       = 1'b1;
        res_status_d = STATUS_OK;
        res_slot_d   = pos_q;
        res_data_d   = dt_rdata;
        res_nv_d     = !is_empty && (pos_q != tail_q) && (nx_rdata < LINK_NULL);
        res_next_d   = res_nv_d ? nx_rdata[SLOT_W-1:0] : '0;
        res_pv_d     = !is_empty && (pos_q != head_q);
        res_prev_d   = res_pv_d ? pv_rdata : '0;
        state_d      = ST_IDLE;
      end

      ST_LINK: begin
        // Advance the free list, store the word and the new slot's backward link, fetch the forward neighbour.
        free_head_d = nx_rdata;
        qprev_d     = pv_rdata;
        nx_addr     = pos_q;
        dt_addr     = new_q;
        dt_we       = 1'b1;
        dt_wdata    = data_q;
        pv_addr     = new_q;
        pv_we       = 1'b1;
        if (is_app) begin
          pv_wdata = is_empty ? '0 : tail_q;
        end else if (cmd_q == CMD_BEFORE) begin
          pv_wdata = (pos_q == head_q) ? '0 : pv_rdata;
        end else begin
          pv_wdata = pos_q;
        end
        state_d = ST_WR1;
      end

      ST_WR1: begin
        // Forward link of the new slot; backward link of its successor.
        nx_addr = new_q;
        nx_we   = 1'b1;
        if (is_app) begin
          nx_wdata = LINK_NULL;
        end else if (cmd_q == CMD_BEFORE) begin
          nx_wdata = {1'b0, pos_q};
        end else begin
          nx_wdata = (pos_q == tail_q) ? LINK_NULL : nx_rdata;
        end
        pv_wdata = new_q;
        if (is_app) begin
          pv_we = 1'b0;
        end else if (cmd_q == CMD_BEFORE) begin
          pv_addr = pos_q;
          pv_we   = 1'b1;
        end else begin
          pv_addr = nx_rdata[SLOT_W-1:0];
          pv_we   = (pos_q != tail_q) && (nx_rdata < LINK_NULL);
        end
        state_d = ST_WR2;
      end

      ST_WR2: begin
        // Point the predecessor at the new slot and settle head, tail and count.
        nx_wdata = {1'b0, new_q};
        if (is_app) begin
          nx_addr = tail_q;
          nx_we   = !is_empty;
          tail_d  = new_q;
          if (is_empty) begin
            head_d = new_q;
          end
        end else if (cmd_q == CMD_BEFORE) begin
          nx_addr = qprev_q;
          nx_we   = (pos_q != head_q);
          if (pos_q == head_q) begin
            head_d = new_q;
          end
        end else begin
          nx_addr = pos_q;
          nx_we   = 1'b1;
          if (pos_q == tail_q) begin
            tail_d = new_q;
          end
        end
        entries_d    = entries_q + COUNT_W'(1);
        done_d       = 1'b1;
        res_status_d = STATUS_OK;
        res_slot_d   = new_q;
        res_data_d   = '0;
        res_next_d   = '0;
        res_nv_d     = 1'b0;
        res_prev_d   = '0;
        res_pv_d     = 1'b0;
        state_d      = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      free_head_q <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      entries_q   <= '0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      free_head_q <= free_head_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      entries_q   <= entries_d;
      done_q      <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    pos_q        <= pos_d;
    data_q       <= data_d;
    new_q        <= new_d;
    qprev_q      <= qprev_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_data_q   <= res_data_d;
    res_next_q   <= res_next_d;
    res_nv_q     <= res_nv_d;
    res_prev_q   <= res_prev_d;
    res_pv_q     <= res_pv_d;
  end

  // Head, tail and count change on the same edge that raises done_o and hold
  // until the next insert's last write pass, so they are read straight out.
  assign busy_o        = (state_q != ST_IDLE);
  assign done_o        = done_q;
  assign status_o      = res_status_q;
  assign slot_o        = res_slot_q;
  assign payload_out_o = res_data_q;
  assign next_slot_o   = res_next_q;
  assign next_valid_o  = res_nv_q;
  assign prev_slot_o   = res_prev_q;
  assign prev_valid_o  = res_pv_q;
  assign head_slot_o   = head_q;
  assign tail_slot_o   = tail_q;
  assign count_o       = entries_q;

endmodule

// File: rtl/alle_ram.sv
// Generic single-port synchronous RAM with registered read data.
module alle_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic                     we_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule
